// ----- design/sojb_pkg.sv -----
// Shared types, constants and helpers for the sequence-ordered jitter buffer.
`default_nettype none

package sojb_pkg;

    // Store geometry
    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Field widths
    localparam int SEQ_W  = 16;
    localparam int HDL_W  = 16;
    localparam int WORD_W = SEQ_W + HDL_W;
    localparam int THR_W  = 6;
    localparam int FILL_W = 6;
    localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam logic [THR_W-1:0] THR_RESET   = 6'd5;
    // Half of the sequence space (32768): serial-number "later" boundary
    localparam logic [SEQ_W-1:0] SERIAL_HALF = 16'h8000;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SEQ_W-1:0]  seq_t;
    typedef logic [HDL_W-1:0]  hdl_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_DUP      = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NONE     = 2'd3
    } push_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_OUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INS_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    // Storage request from the sequencer
    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } ram_req_t;

    // Result of the serial compare unit
    typedef struct packed {
        logic equal;
        logic later;
    } cmp_res_t;

    // Physical slot of logical position offs in the ring starting at head
    function automatic addr_t ring_addr(addr_t head, cnt_t offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offs);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/sojb_ram.sv -----
// Entry store: one write port, one registered read port.
`default_nettype none

module sojb_ram
    import sojb_pkg::*;
(
    input  wire logic     clk,
    input  wire ram_req_t req,
    output logic [WORD_W-1:0] rdata
);

    word_t mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ----- design/sojb_cmp.sv -----
// Wrap-aware serial compare of a stored sequence number against a new one.
`default_nettype none

module sojb_cmp
    import sojb_pkg::*;
(
    input  wire seq_t     entry_seq,
    input  wire seq_t     new_seq,
    output cmp_res_t      res
);

    seq_t diff;

    // Entry is later when (entry - new) mod 2^16 is nonzero and lies in the lower half
    always_comb
    begin
        diff      = entry_seq - new_seq;
        res.equal = (entry_seq == new_seq);
        res.later = (entry_seq != new_seq) && (diff < SERIAL_HALF);
    end

endmodule

`default_nettype wire

// ----- design/sojb_seq.sv -----
// Sequencer: scans, shifts and pops the ring-organized entry store.
`default_nettype none

module sojb_seq
    import sojb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              operation,
    input  wire logic [SEQ_W-1:0]  seq_number,
    input  wire logic [HDL_W-1:0]  packet_handle,
    input  wire logic [THR_W-1:0]  thr,
    input  wire logic [WORD_W-1:0] rdata,
    input  wire cmp_res_t          cmp,
    output ram_req_t               ram_req,
    output seq_t                   item_seq,
    output logic                   busy,
    output logic                   done,
    output push_status_t           status,
    output logic                   pop_valid,
    output logic [SEQ_W-1:0]       out_seq,
    output logic [HDL_W-1:0]       out_handle,
    output logic [FILL_W-1:0]      fill_level
);

    state_t       state_reg, state_next;
    addr_t        head_reg, head_next;
    cnt_t         occ_reg, occ_next;

    logic         op_reg;
    seq_t         seq_reg;
    hdl_t         hdl_reg;
    cnt_t         idx_reg;
    cnt_t         k_reg;
    cnt_t         pos_reg;
    push_status_t status_reg;
    logic         pop_valid_reg;
    seq_t         oseq_reg;
    hdl_t         ohdl_reg;

    logic         accept;
    logic         release_ok;
    logic         scan_last;
    logic         full;
    logic         at_pos;

    // Request handshake and decision terms
    always_comb
    begin
        busy       = !((state_reg == ST_IDLE) || (state_reg == ST_DONE));
        accept     = start && !busy;
        release_ok = (occ_reg != '0) && (CMP_W'(occ_reg) >= CMP_W'(thr));
        scan_last  = ((idx_reg + CNT_W'(1)) == occ_reg);
        full       = (occ_reg == CNT_W'(DEPTH));
        at_pos     = (k_reg == pos_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (accept)
                begin
                    if (operation == OP_POP)
                    begin
                        state_next = release_ok ? ST_POP_RD : ST_DONE;
                    end
                    else
                    begin
                        state_next = (occ_reg == '0) ? ST_INS_CHK : ST_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_RD:   state_next = ST_POP_OUT;
            ST_POP_OUT:  state_next = ST_DONE;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (cmp.equal)
                begin
                    state_next = ST_DONE;
                end
                else if (cmp.later || scan_last)
                begin
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_INS_CHK:  state_next = full ? ST_DONE : ST_SHIFT_RD;
            ST_SHIFT_RD: state_next = at_pos ? ST_DONE : ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Storage requests and ring bookkeeping
    always_comb
    begin
        ram_req.we    = 1'b0;
        ram_req.waddr = ring_addr(head_reg, k_reg);
        ram_req.wdata = rdata;
        ram_req.raddr = ring_addr(head_reg, idx_reg);
        head_next     = head_reg;
        occ_next      = occ_reg;
        unique case (state_reg)
            ST_POP_RD:
            begin
                ram_req.raddr = head_reg;
            end
            ST_POP_OUT:
            begin
                head_next = ring_addr(head_reg, CNT_W'(1));
                occ_next  = occ_reg - CNT_W'(1);
            end
            ST_SHIFT_RD:
            begin
                if (at_pos)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = {seq_reg, hdl_reg};
                    occ_next      = occ_reg + CNT_W'(1);
                end
                else
                begin
                    ram_req.raddr = ring_addr(head_reg, k_reg - CNT_W'(1));
                end
            end
            ST_SHIFT_WR:
            begin
                ram_req.we = 1'b1;
            end
            default:
            begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    // Request capture, scan position and result registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (accept)
                begin
                    op_reg        <= operation;
                    seq_reg       <= seq_number;
                    hdl_reg       <= packet_handle;
                    idx_reg       <= '0;
                    pos_reg       <= '0;
                    status_reg    <= STAT_NONE;
                    pop_valid_reg <= 1'b0;
                    oseq_reg      <= '0;
                    ohdl_reg      <= '0;
                end
            end
            ST_POP_OUT:
            begin
                pop_valid_reg <= 1'b1;
                oseq_reg      <= rdata[WORD_W-1 -: SEQ_W];
                ohdl_reg      <= rdata[HDL_W-1:0];
            end
            ST_SCAN_CMP:
            begin
                if (cmp.equal)
                begin
                    status_reg <= STAT_DUP;
                end
                else if (cmp.later)
                begin
                    pos_reg <= idx_reg;
                end
                else if (scan_last)
                begin
                    pos_reg <= occ_reg;
                end
                idx_reg <= idx_reg + CNT_W'(1);
            end
            ST_INS_CHK:
            begin
                if (full)
                begin
                    status_reg <= STAT_FULL;
                end
                k_reg <= occ_reg;
            end
            ST_SHIFT_RD:
            begin
                if (at_pos)
                begin
                    status_reg <= STAT_INSERTED;
                end
            end
            ST_SHIFT_WR:
            begin
                k_reg <= k_reg - CNT_W'(1);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Result ports
    always_comb
    begin
        item_seq   = seq_reg;
        done       = (state_reg == ST_DONE);
        status     = status_reg;
        pop_valid  = pop_valid_reg;
        out_seq    = oseq_reg;
        out_handle = ohdl_reg;
        fill_level = FILL_W'(occ_reg);
    end

    // Occupancy stays within the store
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // Occupancy only moves on the way into a completed request
    a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> (state_reg == ST_DONE))
        else $error("occupancy changed outside completion");

    // A released packet always reports a pop request
    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pop_valid) |-> (status == STAT_NONE) && (op_reg == OP_POP))
        else $error("pop result carries push status");

    // Writes happen only while moving or inserting entries
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> ((state_reg == ST_SHIFT_RD) || (state_reg == ST_SHIFT_WR)))
        else $error("store written outside shift phase");

    // An accepted request makes the block busy or completes at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted request lost");

endmodule

`default_nettype wire

// ----- design/seq_ordered_jitter_buffer.sv -----
// Top level of the sequence-ordered jitter buffer.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// operation 0 pushes (seq_number, packet_handle); operation 1 asks for a pop.
// Each request yields one result, shown for exactly one cycle while done is
// high: push_status, pop_valid, out_seq, out_handle and fill_level.
// The receiver cannot stall; results must be taken in that cycle.
// A releasing pop reads the head entry and shows it; a pop that releases
// nothing goes straight to done. A push compares stored entries from the
// oldest until an equal or later one, checks for room, moves each later
// entry up a slot (read, then write-back) and writes itself into the freed
// slot; s compares plus m moves never exceed DEPTH. A duplicate ends at its
// compare, a push into a full store at the room check. One request is
// worked on at a time; a new one may be taken in the same cycle its
// predecessor's result is shown.
// cfg_wr_en/cfg_wr_data load playout_threshold (reset value 5); write it only
// while no request is in progress. Reset empties the buffer and clears the
// sequencer; stored entries are left as they are and never read unwritten.
`default_nettype none

module seq_ordered_jitter_buffer
    import sojb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              operation,
    input  wire logic [SEQ_W-1:0]  seq_number,
    input  wire logic [HDL_W-1:0]  packet_handle,
    input  wire logic              cfg_wr_en,
    input  wire logic [THR_W-1:0]  cfg_wr_data,
    output logic                   done,
    output logic [1:0]             push_status,
    output logic                   pop_valid,
    output logic [SEQ_W-1:0]       out_seq,
    output logic [HDL_W-1:0]       out_handle,
    output logic [FILL_W-1:0]      fill_level
);

    logic [THR_W-1:0]  thr_reg;
    ram_req_t          ram_req;
    logic [WORD_W-1:0] rdata;
    cmp_res_t          cmp_res;
    seq_t              item_seq;
    push_status_t      status;

    // Playout threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    sojb_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operation     (operation),
        .seq_number    (seq_number),
        .packet_handle (packet_handle),
        .thr           (thr_reg),
        .rdata         (rdata),
        .cmp           (cmp_res),
        .ram_req       (ram_req),
        .item_seq      (item_seq),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .pop_valid     (pop_valid),
        .out_seq       (out_seq),
        .out_handle    (out_handle),
        .fill_level    (fill_level)
    );

    sojb_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    sojb_cmp u_cmp (
        .entry_seq (rdata[WORD_W-1 -: SEQ_W]),
        .new_seq   (item_seq),
        .res       (cmp_res)
    );

    // Status code out as plain bits
    assign push_status = 2'(status);

endmodule

`default_nettype wire

// ----- tb/seq_ordered_jitter_buffer_test.sv -----
// Self-checking testbench for the sequence-ordered jitter buffer.
`default_nettype none

module seq_ordered_jitter_buffer_test;
    import sojb_pkg::*;

    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [THR_W-1:0]  thr_t;

    // One result as the block reports it
    typedef struct packed {
        push_status_t status;
        logic         valid;
        seq_t         oseq;
        hdl_t         ohdl;
        fill_t        fill;
    } jb_result_t;

    // One stored packet in the shadow buffer
    typedef struct packed {
        seq_t seq;
        hdl_t hdl;
    } held_pkt_t;

    // Directed row: threshold in force, request, optional pinned result
    typedef struct packed {
        thr_t       thr;
        logic       op;
        seq_t       seq;
        hdl_t       hdl;
        logic       pinned;
        jb_result_t res;
    } plan_row_t;

    localparam int N_PLAN      = 21;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 170;
    localparam int MAX_REPORTS = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic operation = OP_PUSH;
    seq_t seq_number = '0;
    hdl_t packet_handle = '0;
    logic cfg_wr_en = 1'b0;
    thr_t cfg_wr_data = '0;
    logic busy;
    logic done;
    logic [1:0] push_status;
    logic pop_valid;
    seq_t out_seq;
    hdl_t out_handle;
    fill_t fill_level;

    // Shadow buffer, threshold copy and results still to come
    held_pkt_t  held_pkts[$];
    thr_t       playout_thr = THR_RESET;
    jb_result_t pending_results[$];

    int errors = 0;
    int n_requests = 0;
    int n_inserted = 0;
    int n_dup = 0;
    int n_full = 0;
    int n_released = 0;
    int n_empty_pops = 0;

    plan_row_t plan [N_PLAN];
    thr_t      phase_thr [N_PHASES];

    seq_ordered_jitter_buffer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .seq_number    (seq_number),
        .packet_handle (packet_handle),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .push_status   (push_status),
        .pop_valid     (pop_valid),
        .out_seq       (out_seq),
        .out_handle    (out_handle),
        .fill_level    (fill_level)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the shadow buffer and return what the block must report
    function automatic jb_result_t reorder_step(logic op, seq_t seq, hdl_t hdl);
        jb_result_t r;
        held_pkt_t  p;
        int         pos;
        int         i;
        bit         dup;
        int         thr;
        r = '0;
        r.status = STAT_NONE;
        if (op == OP_PUSH)
        begin
            pos = held_pkts.size();
            dup = 1'b0;
            // walk from the oldest: equal number drops, first later entry marks the slot
            for (i = 0; i < held_pkts.size(); i++)
            begin
                if (held_pkts[i].seq == seq)
                begin
                    dup = 1'b1;
                    break;
                end
                if (seq_t'(held_pkts[i].seq - seq) < SERIAL_HALF)
                begin
                    pos = i;
                    break;
                end
            end
            if (dup)
            begin
                r.status = STAT_DUP;
            end
            else if (held_pkts.size() >= DEPTH)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                p.seq = seq;
                p.hdl = hdl;
                held_pkts.insert(pos, p);
                r.status = STAT_INSERTED;
            end
        end
        else
        begin
            // a zero threshold acts as one
            thr = (playout_thr == 0) ? 1 : int'(playout_thr);
            if (held_pkts.size() > 0 && held_pkts.size() >= thr)
            begin
                p = held_pkts[0];
                held_pkts.delete(0);
                r.valid = 1'b1;
                r.oseq = p.seq;
                r.ohdl = p.hdl;
            end
        end
        r.fill = fill_t'(held_pkts.size());
        return r;
    endfunction

    // Drive one request, wait for acceptance, queue its expected result
    task automatic send_request(logic op, seq_t seq, hdl_t hdl, logic pinned,
                                jb_result_t pinned_res);
        jb_result_t r;
        start <= 1'b1;
        operation <= op;
        seq_number <= seq;
        packet_handle <= hdl;
        do
            @(posedge clk);
        while (busy);
        r = reorder_step(op, seq, hdl);
        n_requests++;
        if (op == OP_PUSH)
        begin
            if (r.status == STAT_INSERTED) n_inserted++;
            else if (r.status == STAT_DUP) n_dup++;
            else n_full++;
        end
        else if (r.valid) n_released++;
        else n_empty_pops++;
        pending_results.insert(pending_results.size(), pinned ? pinned_res : r);
    endtask

    // Random idle after a request; quiet phases never idle
    task automatic idle_after(bit allow);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (allow)
        begin
            if (r >= 90) gap = $urandom_range(10, 60);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop issuing and let every outstanding request finish
    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Threshold register write, only while idle
    task automatic write_threshold(thr_t v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        playout_thr = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Result checker: every done strobe takes the oldest expectation
    always @(posedge clk)
    begin
        jb_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: stray result, expected none, actual %0h/%0h/%0h/%0h/%0h",
                             $time, push_status, pop_valid, out_seq, out_handle,
                             fill_level);
            end
            else
            begin
                e = pending_results[0];
                pending_results.delete(0);
                check_field("push_status", e.status, push_status);
                check_field("pop_valid", e.valid, pop_valid);
                check_field("out_seq", e.oseq, out_seq);
                check_field("out_handle", e.ohdl, out_handle);
                check_field("fill_level", e.fill, fill_level);
            end
        end
    end

    // Watchdog
    initial
    begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        int   ph;
        int   k;
        int   pick;
        int   push_pct;
        seq_t base;
        seq_t s;

        plan = '{
            // reset threshold: ordering across the wrap, duplicates, hold below threshold
            '{6'd5, OP_POP,  16'h0000, 16'h0000, 1'b1, '{STAT_NONE,     1'b0, 16'h0, 16'h0, 6'd0}},
            '{6'd5, OP_PUSH, 16'h0000, 16'h0000, 1'b1, '{STAT_INSERTED, 1'b0, 16'h0, 16'h0, 6'd1}},
            '{6'd5, OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, '{STAT_INSERTED, 1'b0, 16'h0, 16'h0, 6'd2}},
            '{6'd5, OP_PUSH, 16'h0000, 16'h1234, 1'b1, '{STAT_DUP,      1'b0, 16'h0, 16'h0, 6'd2}},
            '{6'd5, OP_PUSH, 16'h8000, 16'hAAAA, 1'b1, '{STAT_INSERTED, 1'b0, 16'h0, 16'h0, 6'd3}},
            '{6'd5, OP_PUSH, 16'h7FFF, 16'h5555, 1'b1, '{STAT_INSERTED, 1'b0, 16'h0, 16'h0, 6'd4}},
            '{6'd5, OP_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{STAT_NONE,     1'b0, 16'h0, 16'h0, 6'd4}},
            '{6'd5, OP_PUSH, 16'h4000, 16'h0F0F, 1'b1, '{STAT_INSERTED, 1'b0, 16'h0, 16'h0, 6'd5}},
            '{6'd5, OP_POP,  16'h0000, 16'h0000, 1'b0, '0},
            '{6'd5, OP_POP,  16'h0000, 16'h0000, 1'b1, '{STAT_NONE,     1'b0, 16'h0, 16'h0, 6'd4}},
            '{6'd5, OP_PUSH, 16'hFFFF, 16'h0001, 1'b1, '{STAT_DUP,      1'b0, 16'h0, 16'h0, 6'd4}},
            '{6'd5, OP_PUSH, 16'h0001, 16'hFFFF, 1'b0, '0},
            '{6'd5, OP_POP,  16'h0000, 16'h0000, 1'b0, '0},
            // lowest threshold: drain, then pop of an empty store
            '{6'd1, OP_POP,  16'h0000, 16'h0000, 1'b0, '0},
            '{6'd1, OP_POP,  16'h0000, 16'h0000, 1'b0, '0},
            '{6'd1, OP_POP,  16'h0000, 16'h0000, 1'b0, '0},
            '{6'd1, OP_POP,  16'h0000, 16'h0000, 1'b0, '0},
            '{6'd1, OP_POP,  16'h0000, 16'h0000, 1'b1, '{STAT_NONE,     1'b0, 16'h0, 16'h0, 6'd0}},
            // zero threshold on an empty store, then one above the depth
            '{6'd0, OP_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{STAT_NONE,     1'b0, 16'h0, 16'h0, 6'd0}},
            '{6'd63, OP_PUSH, 16'h1234, 16'h4321, 1'b1, '{STAT_INSERTED, 1'b0, 16'h0, 16'h0, 6'd1}},
            '{6'd63, OP_POP,  16'h0000, 16'h0000, 1'b1, '{STAT_NONE,     1'b0, 16'h0, 16'h0, 6'd1}}
        };
        phase_thr = '{6'd63, 6'd1, 6'd32, 6'd0, 6'd33, 6'd5,
                      6'd63, 6'd2, 6'd20, 6'd1, 6'd31, 6'd63};

        // reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (k = 0; k < N_PLAN; k++)
        begin
            if (plan[k].thr != playout_thr)
            begin
                drain();
                write_threshold(plan[k].thr);
            end
            send_request(plan[k].op, plan[k].seq, plan[k].hdl, plan[k].pinned, plan[k].res);
            idle_after(1'b1);
        end

        // random phases: mostly in-order arrivals with jitter, some repeats and jumps
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            write_threshold(phase_thr[ph]);
            push_pct = (phase_thr[ph] >= 6'd32) ? 75 : 55;
            base = seq_t'($urandom);
            if (ph % 2 == 1) base = 16'hFFFF - seq_t'($urandom_range(0, 60));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 65)
                    begin
                        s = base + seq_t'($urandom_range(0, 6)) - 16'd3;
                        base = base + 16'd1;
                    end
                    else if (pick < 82 && held_pkts.size() > 0)
                        s = held_pkts[$urandom_range(0, held_pkts.size() - 1)].seq;
                    else if (pick < 90)
                    begin
                        base = seq_t'($urandom);
                        s = base;
                    end
                    else
                        s = seq_t'($urandom);
                    send_request(OP_PUSH, s, hdl_t'($urandom), 1'b0, '0);
                end
                else
                    send_request(OP_POP, seq_t'($urandom), hdl_t'($urandom), 1'b0, '0);
                idle_after(ph % 3 != 2);
            end
        end

        drain();
        repeat (16) @(posedge clk);

        $display("Ran %0d requests under %0d thresholds: %0d inserted, %0d dup, %0d full.",
                 n_requests, N_PHASES + 4, n_inserted, n_dup, n_full);
        $display("Pops: %0d released a packet, %0d held back; %0d mismatches.",
                 n_released, n_empty_pops, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/sojb_pkg.sv
design/sojb_ram.sv
design/sojb_cmp.sv
design/sojb_seq.sv
design/seq_ordered_jitter_buffer.sv
tb/seq_ordered_jitter_buffer_test.sv
